// File: design/dcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dominant channel colorize package
// Shared types and constants for the 3x3 dominant channel colorize unit.
// ----------------------------------------------------------------------------
package dcc_pkg;

   localparam int CHAN_W            = 8;
   localparam int POS_W             = 10;
   localparam int CSR_DATA_W        = 11;
   localparam int CSR_INDEX_W       = 2;
   localparam int ALPHA_W           = 9;
   localparam int GAIN_W            = 10;
   localparam int WIN_TAPS          = 9;
   localparam int WIN_CENTER        = 4;
   localparam int CHAN_SAT          = 255;
   localparam int GAIN_UNITY        = 256;
   localparam int ALPHA_LIMIT       = 256;
   localparam int DIM_MIN           = 3;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // Result buffer depth; it covers the items still in the pipeline.
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_Q8     = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   localparam int PIXEL_W = $bits(pixel_type);

   typedef struct packed {
      logic [CHAN_W-1:0] in_blue;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_red;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_red;
      logic [POS_W-1:0]  out_column;
      logic [POS_W-1:0]  out_line;
      logic              frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic                          valid;
      pixel_type [WIN_TAPS-1:0]      px;
      logic [POS_W-1:0]              column;
      logic [POS_W-1:0]              line;
      logic                          last;
   } window_type;

endpackage

// File: design/dcc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dominant channel colorize stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface dcc_stream_if #(parameter type payload_type = logic) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: design/dcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dcc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/dcc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster window stage
// Tracks the raster position, keeps two line stores in RAM and shifts the
// 3x3 window one column per accepted pixel.
// ----------------------------------------------------------------------------
module dcc_window import dcc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int LW = $clog2(MAX_HEIGHT),
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  pixel_type     pixel,
   input  logic [WW-1:0] width_eff,
   input  logic [HW-1:0] height_eff,
   output logic          stage_busy,
   output window_type    window
);

   logic [CW-1:0] col_ff, col_in;
   logic [LW-1:0] line_ff, line_in;
   logic [CW:0]   col_plus;
   logic [LW:0]   line_plus;
   logic [CW-1:0] col_m1;
   logic [LW-1:0] line_m1;
   logic          col_wrap;
   logic          last_pos;

   logic              s1_valid_ff;
   logic              s1_emit_ff;
   logic              s1_last_ff;
   pixel_type         s1_px_ff;
   logic [CW-1:0]     s1_col_ff;
   logic [POS_W-1:0]  s1_column_ff;
   logic [POS_W-1:0]  s1_line_ff;

   logic              s2_valid_ff;
   logic              s2_last_ff;
   logic [POS_W-1:0]  s2_column_ff;
   logic [POS_W-1:0]  s2_line_ff;
   pixel_type         win_ff [WIN_TAPS];

   logic [PIXEL_W-1:0] upper_q;
   logic [PIXEL_W-1:0] lower_q;

   always_comb begin
      col_plus  = {1'b0, col_ff} + (CW + 1)'(1);
      line_plus = {1'b0, line_ff} + (LW + 1)'(1);
      col_m1    = col_ff - CW'(1);
      line_m1   = line_ff - LW'(1);
      col_wrap  = 32'(col_plus) >= 32'(width_eff);
      last_pos  = (32'(col_plus) == 32'(width_eff)) && (32'(line_plus) == 32'(height_eff));
      col_in    = col_ff;
      line_in   = line_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (32'(line_plus) >= 32'(height_eff)) begin
               line_in = '0;
            end else begin
               line_in = line_plus[LW-1:0];
            end
         end else begin
            col_in = col_plus[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         line_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         line_ff     <= line_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff     <= pixel;
         s1_col_ff    <= col_ff;
         s1_emit_ff   <= (32'(col_ff) >= 2) && (32'(line_ff) >= 2);
         s1_last_ff   <= last_pos;
         s1_column_ff <= POS_W'(col_m1);
         s1_line_ff   <= POS_W'(line_m1);
      end
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r * 3]     <= win_ff[r * 3 + 1];
            win_ff[r * 3 + 1] <= win_ff[r * 3 + 2];
         end
         win_ff[2]    <= pixel_type'(upper_q);
         win_ff[5]    <= pixel_type'(lower_q);
         win_ff[8]    <= s1_px_ff;
         s2_last_ff   <= s1_last_ff;
         s2_column_ff <= s1_column_ff;
         s2_line_ff   <= s1_line_ff;
      end
   end

   // The store is read when the pixel is accepted and written back in the cycle
   // after. Consecutive pixels never share a column, so no forwarding is needed.
   dcc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (lower_q),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_q)
   );

   dcc_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_lower_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (PIXEL_W'(s1_px_ff)),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (lower_q)
   );

   always_comb begin
      window.valid  = s2_valid_ff;
      window.column = s2_column_ff;
      window.line   = s2_line_ff;
      window.last   = s2_last_ff;
      for (int k = 0; k < WIN_TAPS; k++) begin
         window.px[k] = win_ff[k];
      end
   end

   assign stage_busy = s1_valid_ff;

endmodule

// File: design/dcc_colorize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dominant channel colorize datapath
// Finds the per-channel window maximum, picks the dominant channel and scales
// the center pixel with saturation.
// ----------------------------------------------------------------------------
module dcc_colorize import dcc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  window_type          window,
   input  logic [ALPHA_W-1:0]  alpha,
   output logic                stage_busy,
   output logic                result_valid,
   output rsp_payload_type     result
);

   localparam logic [1:0] DOM_BLUE  = 2'd0;
   localparam logic [1:0] DOM_GREEN = 2'd1;
   localparam logic [1:0] DOM_RED   = 2'd2;

   logic [CHAN_W-1:0] max_blue, max_green, max_red;
   logic [1:0]        dominant;
   logic [GAIN_W-1:0] gain_up, gain_down;

   logic                          sa_valid_ff;
   pixel_type                     sa_center_ff;
   logic [GAIN_W-1:0]             sa_gain_blue_ff;
   logic [GAIN_W-1:0]             sa_gain_green_ff;
   logic [GAIN_W-1:0]             sa_gain_red_ff;
   logic [POS_W-1:0]              sa_column_ff;
   logic [POS_W-1:0]              sa_line_ff;
   logic                          sa_last_ff;

   function automatic logic [CHAN_W-1:0] scale_sat(input logic [CHAN_W-1:0] value,
                                                   input logic [GAIN_W-1:0] gain);
      logic [CHAN_W+GAIN_W-1:0] prod;
      logic [GAIN_W-1:0]        shifted;
      prod    = (CHAN_W + GAIN_W)'(value) * (CHAN_W + GAIN_W)'(gain);
      shifted = prod[CHAN_W+GAIN_W-1:8];
      if (32'(shifted) > CHAN_SAT) begin
         return CHAN_W'(CHAN_SAT);
      end
      return shifted[CHAN_W-1:0];
   endfunction

   always_comb begin
      max_blue  = '0;
      max_green = '0;
      max_red   = '0;
      for (int k = 0; k < WIN_TAPS; k++) begin
         if (window.px[k].blue > max_blue) begin
            max_blue = window.px[k].blue;
         end
         if (window.px[k].green > max_green) begin
            max_green = window.px[k].green;
         end
         if (window.px[k].red > max_red) begin
            max_red = window.px[k].red;
         end
      end
      // Red wins any tie, then green wins over blue.
      if (max_red >= max_green && max_red >= max_blue) begin
         dominant = DOM_RED;
      end else if (max_green >= max_blue) begin
         dominant = DOM_GREEN;
      end else begin
         dominant = DOM_BLUE;
      end
      gain_up   = GAIN_W'(GAIN_UNITY) + GAIN_W'(alpha);
      gain_down = GAIN_W'(GAIN_UNITY) - GAIN_W'(alpha);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= window.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (window.valid) begin
         sa_center_ff     <= window.px[WIN_CENTER];
         sa_gain_blue_ff  <= (dominant == DOM_BLUE)  ? gain_up : gain_down;
         sa_gain_green_ff <= (dominant == DOM_GREEN) ? gain_up : gain_down;
         sa_gain_red_ff   <= (dominant == DOM_RED)   ? gain_up : gain_down;
         sa_column_ff     <= window.column;
         sa_line_ff       <= window.line;
         sa_last_ff       <= window.last;
      end
   end

   always_comb begin
      result.out_blue   = scale_sat(sa_center_ff.blue, sa_gain_blue_ff);
      result.out_green  = scale_sat(sa_center_ff.green, sa_gain_green_ff);
      result.out_red    = scale_sat(sa_center_ff.red, sa_gain_red_ff);
      result.out_column = sa_column_ff;
      result.out_line   = sa_line_ff;
      result.frame_end  = sa_last_ff;
   end

   assign result_valid = sa_valid_ff;
   assign stage_busy   = sa_valid_ff;

endmodule

// File: design/dcc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Small register FIFO that holds finished results while the receiver stalls.
// ----------------------------------------------------------------------------
module dcc_out_fifo import dcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_payload_type       push_data,
   output logic [OUT_CNT_W-1:0]  count,
   dcc_stream_if.source          rsp
);

   rsp_payload_type       mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]  count_ff, count_in;
   logic                  pop;

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == OUT_DEPTH - 1) ? '0 : wr_ptr_ff + OUT_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == OUT_DEPTH - 1) ? '0 : rd_ptr_ff + OUT_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp.valid   = count_ff != '0;
   assign rsp.payload = mem_ff[rd_ptr_ff];
   assign count       = count_ff;

endmodule

// File: design/dominant_channel_colorize_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dominant channel colorize 3x3 unit
// Takes BGR pixels in raster order and returns one colorized result per
// interior pixel: the window's dominant channel is boosted, the others cut.
//
// Usage:
//   req carries one pixel per request; rsp carries the scaled center pixel
//   with its column, row and an end-of-frame flag. Border pixels give no
//   result. The csr port writes frame width, frame height and alpha; write
//   it only while no request is in flight.
//   A request accepted on req passes the line store read, the window shift,
//   the maximum and gain select and the multiply into the result buffer,
//   in that order, before it is offered on rsp. Throughput: one request per
//   cycle while the receiver takes results. The line stores are read on
//   acceptance and written back the next cycle, one port each.
//   An eight-entry result buffer parts the two sides. When the receiver
//   stalls, req keeps accepting until the buffer plus the three pipeline
//   stages hold eight items, then drops ready until results are taken.
//   Reset clears the raster position, the pipeline and the buffer and loads
//   640 x 480 with alpha 0; the line stores are not cleared.
// ----------------------------------------------------------------------------
module dominant_channel_colorize_3x3_unit import dcc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   dcc_stream_if.sink              req,
   dcc_stream_if.source            rsp,
   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int WIDTH_RESET  = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
   localparam int HEIGHT_RESET = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                                 MAX_HEIGHT : FRAME_HEIGHT_RESET;

   logic [WW-1:0]      width_ff, width_in;
   logic [HW-1:0]      height_ff, height_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   logic                  accept;
   pixel_type             pixel;
   window_type            window;
   logic                  window_busy;
   logic                  colorize_busy;
   logic                  result_valid;
   rsp_payload_type       result;
   logic [OUT_CNT_W-1:0]  fifo_count;
   logic [OUT_CNT_W+1:0]  pending;

   // Out-of-range geometry and alpha are clamped when written.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      alpha_in  = alpha_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               if (32'(csr_data) < DIM_MIN) begin
                  width_in = WW'(DIM_MIN);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_data);
               end
            end
            REG_FRAME_HEIGHT: begin
               if (32'(csr_data) < DIM_MIN) begin
                  height_in = HW'(DIM_MIN);
               end else if (32'(csr_data) > MAX_HEIGHT) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(csr_data);
               end
            end
            REG_ALPHA_Q8: begin
               if (32'(csr_data[ALPHA_W-1:0]) > ALPHA_LIMIT) begin
                  alpha_in = ALPHA_W'(ALPHA_LIMIT);
               end else begin
                  alpha_in = csr_data[ALPHA_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(WIDTH_RESET);
         height_ff <= HW'(HEIGHT_RESET);
         alpha_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         alpha_ff  <= alpha_in;
      end
   end

   // Credit check: every item in the pipeline has a buffer slot reserved.
   assign pending = (OUT_CNT_W + 2)'(fifo_count) + (OUT_CNT_W + 2)'(window_busy)
                  + (OUT_CNT_W + 2)'(window.valid) + (OUT_CNT_W + 2)'(colorize_busy);
   assign req.ready = 32'(pending) < OUT_DEPTH;
   assign accept    = req.valid && req.ready;

   always_comb begin
      pixel.blue  = req.payload.in_blue;
      pixel.green = req.payload.in_green;
      pixel.red   = req.payload.in_red;
   end

   dcc_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pixel      (pixel),
      .width_eff  (width_ff),
      .height_eff (height_ff),
      .stage_busy (window_busy),
      .window     (window)
   );

   dcc_colorize u_colorize (
      .clock        (clock),
      .reset        (reset),
      .window       (window),
      .alpha        (alpha_ff),
      .stage_busy   (colorize_busy),
      .result_valid (result_valid),
      .result       (result)
   );

   dcc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .count     (fifo_count),
      .rsp       (rsp)
   );

endmodule

// File: sim/tb_dominant_channel_colorize_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dominant channel colorize 3x3 unit testbench
// Streams raster frames of hand-picked and random pixels through the unit
// while frame geometry and gain change between frames and inside them. A
// pixel-accurate model of the line stores, the window, the dominance pick
// and the saturating gain predicts each result, and the results coming back
// are compared with it in order.
// ----------------------------------------------------------------------------
module tb_dominant_channel_colorize_3x3_unit;
   import dcc_pkg::*;

   localparam int FRAME_MAX     = 1024;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int WAIT_MAX      = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int RESULT_WAIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic [1:0] {DOM_BLUE, DOM_GREEN, DOM_RED} dominant_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   dcc_stream_if #(.payload_type(req_payload_type)) req_if ();
   dcc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   dominant_channel_colorize_3x3_unit #(
      .MAX_WIDTH  (FRAME_MAX),
      .MAX_HEIGHT (FRAME_MAX)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model state: register copies, line stores, window and raster position.
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   logic [ALPHA_W-1:0]    alpha_reg;
   pixel_type             upper_row [FRAME_MAX];
   pixel_type             lower_row [FRAME_MAX];
   pixel_type             window [WIN_TAPS];
   int unsigned           col_pos;
   int unsigned           line_pos;

   req_payload_type pixel_queue [$];
   rsp_payload_type expected_results [$];
   int unsigned     mismatch_count = 0;
   bit              idle_on = 1'b1;
   int unsigned     req_gap;
   int unsigned     rsp_stall;

   function automatic int unsigned clamp_dim(int unsigned v);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > FRAME_MAX) return FRAME_MAX;
      return v;
   endfunction

   function automatic logic [CHAN_W-1:0] scale_channel(logic [CHAN_W-1:0] v,
                                                       int unsigned gain);
      int unsigned product;
      product = (v * gain) >> 8;
      return (product > CHAN_SAT) ? CHAN_W'(CHAN_SAT) : CHAN_W'(product);
   endfunction

   function automatic void colorize_pixel(req_payload_type item);
      pixel_type         incoming;
      pixel_type         center;
      logic [CHAN_W-1:0] max_r, max_g, max_b;
      dominant_type      dominant;
      int unsigned       cols, rows, alpha, boost, cut;
      rsp_payload_type   result;
      cols  = clamp_dim(width_reg);
      rows  = clamp_dim(height_reg);
      alpha = (alpha_reg > ALPHA_LIMIT) ? ALPHA_LIMIT : alpha_reg;
      incoming.red   = item.in_red;
      incoming.green = item.in_green;
      incoming.blue  = item.in_blue;
      for (int r = 0; r < 3; r++) begin
         window[r*3]   = window[r*3+1];
         window[r*3+1] = window[r*3+2];
      end
      window[2] = upper_row[col_pos];
      window[5] = lower_row[col_pos];
      window[8] = incoming;
      upper_row[col_pos] = lower_row[col_pos];
      lower_row[col_pos] = incoming;
      if (col_pos >= 2 && line_pos >= 2) begin
         max_r = '0;
         max_g = '0;
         max_b = '0;
         for (int k = 0; k < WIN_TAPS; k++) begin
            if (window[k].red > max_r) max_r = window[k].red;
            if (window[k].green > max_g) max_g = window[k].green;
            if (window[k].blue > max_b) max_b = window[k].blue;
         end
         // Red takes any tie it is part of; green beats blue on a tie.
         if (max_r >= max_g && max_r >= max_b) dominant = DOM_RED;
         else if (max_g >= max_b) dominant = DOM_GREEN;
         else dominant = DOM_BLUE;
         boost  = GAIN_UNITY + alpha;
         cut    = GAIN_UNITY - alpha;
         center = window[WIN_CENTER];
         result.out_red    = scale_channel(center.red, (dominant == DOM_RED) ? boost : cut);
         result.out_green  = scale_channel(center.green,
                                           (dominant == DOM_GREEN) ? boost : cut);
         result.out_blue   = scale_channel(center.blue, (dominant == DOM_BLUE) ? boost : cut);
         result.out_column = POS_W'(col_pos - 1);
         result.out_line   = POS_W'(line_pos - 1);
         result.frame_end  = (col_pos == cols - 1 && line_pos == rows - 1);
         expected_results.push_back(result);
      end
      col_pos++;
      if (col_pos >= cols) begin
         col_pos = 0;
         line_pos++;
         if (line_pos >= rows) line_pos = 0;
      end
   endfunction

   function automatic void check_result(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_results.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("unexpected result at column %0d line %0d", got.out_column, got.out_line);
         mismatch_count++;
         return;
      end
      want = expected_results.pop_front();
      if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
          got.out_red !== want.out_red || got.out_column !== want.out_column ||
          got.out_line !== want.out_line || got.frame_end !== want.frame_end) begin
         if (mismatch_count < REPORT_LIMIT) begin
            $display("result mismatch: expected b %0d g %0d r %0d col %0d line %0d end %0b",
                     want.out_blue, want.out_green, want.out_red, want.out_column,
                     want.out_line, want.frame_end);
            $display("                 got      b %0d g %0d r %0d col %0d line %0d end %0b",
                     got.out_blue, got.out_green, got.out_red, got.out_column,
                     got.out_line, got.frame_end);
         end
         mismatch_count++;
      end
   endfunction

   function automatic int unsigned draw_wait();
      return idle_on ? $urandom_range(0, WAIT_MAX) : 0;
   endfunction

   // Pixels still needed to bring the raster position back to the frame start.
   function automatic int unsigned frame_pixels_left();
      int unsigned cols, rows, row_left, rows_after;
      cols       = clamp_dim(width_reg);
      rows       = clamp_dim(height_reg);
      row_left   = (col_pos >= cols) ? 1 : cols - col_pos;
      rows_after = (line_pos >= rows - 1) ? 0 : rows - 1 - line_pos;
      return row_left + rows_after * cols;
   endfunction

   function automatic logic [CHAN_W-1:0] pick_level(bit palette);
      if (!palette) return CHAN_W'($urandom);
      case ($urandom_range(0, 2))
         0: return 8'h00;
         1: return 8'h80;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic int unsigned pick_dim();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
   endfunction

   function automatic int unsigned pick_alpha();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return ALPHA_LIMIT;
         2: return $urandom_range(ALPHA_LIMIT + 1, 511);
         default: return $urandom_range(1, ALPHA_LIMIT - 1);
      endcase
   endfunction

   function automatic void push_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                      logic [CHAN_W-1:0] blue);
      req_payload_type item;
      item.in_red   = red;
      item.in_green = green;
      item.in_blue  = blue;
      pixel_queue.push_back(item);
   endfunction

   function automatic void queue_pixels(int unsigned count, bit palette);
      repeat (count) push_pixel(pick_level(palette), pick_level(palette), pick_level(palette));
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= CSR_DATA_W'(value);
      case (index)
         REG_FRAME_WIDTH:  width_reg  = CSR_DATA_W'(value);
         REG_FRAME_HEIGHT: height_reg = CSR_DATA_W'(value);
         REG_ALPHA_Q8:     alpha_reg  = ALPHA_W'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Holds the sender until every request is taken and every result is back.
   task automatic drain();
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_if.valid) @(negedge clock);
      while (expected_results.size() != 0 && waited < RESULT_WAIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%0d expected results never arrived", expected_results.size());
         mismatch_count += expected_results.size();
         expected_results.delete();
      end
   endtask

   // Request driver: valid stays up across back-to-back requests.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else begin
         if (req_if.valid && req_if.ready) colorize_pixel(req_if.payload);
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_if.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (pixel_queue.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= pixel_queue.pop_front();
               req_gap        <= draw_wait();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure after each result.
   always @(posedge clock) begin
      int unsigned pause;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         check_result(rsp_if.payload);
         pause = draw_wait();
         rsp_if.ready <= (pause == 0);
         rsp_stall    <= pause;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         if (rsp_stall == 1) rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      int unsigned left;
      int unsigned random_pixels;
      bit          palette;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      width_reg      = FRAME_WIDTH_RESET;
      height_reg     = FRAME_HEIGHT_RESET;
      alpha_reg      = '0;
      col_pos        = 0;
      line_pos       = 0;
      random_pixels  = 0;
      foreach (window[k]) window[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A few requests at the reset geometry, then the width drops to the value of
      // the column counter, which must wrap on its next advance.
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h5A, 8'hA5, 8'h3C);
      drain();
      write_reg(REG_SPARE, 2047);
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_FRAME_HEIGHT, 1);
      write_reg(REG_ALPHA_Q8, ALPHA_LIMIT);
      // Gray center under tied maxima: red wins and saturates, the rest go to zero.
      left = frame_pixels_left();
      repeat (left) push_pixel(8'h80, 8'h80, 8'h80);
      drain();
      // Alpha above the limit; green and blue tie above red, so green wins.
      write_reg(REG_ALPHA_Q8, 511);
      repeat (9) push_pixel(8'd100, 8'd200, 8'd200);
      drain();

      // An oversized height clamps to the tallest frame. Run a stretch of it
      // with no idling, then cut the height below the current row.
      idle_on = 1'b0;
      write_reg(REG_FRAME_HEIGHT, 2047);
      write_reg(REG_ALPHA_Q8, $urandom_range(1, ALPHA_LIMIT - 1));
      queue_pixels(30, 1'b1);
      drain();
      write_reg(REG_FRAME_HEIGHT, 5);
      queue_pixels(frame_pixels_left(), 1'b0);
      drain();

      while (random_pixels < RANDOM_ITEMS) begin
         palette = ($urandom_range(0, 2) == 0);
         // The width may only grow at a frame start, where both stores refill.
         if (col_pos != 0 || line_pos != 0) begin
            left = frame_pixels_left();
            queue_pixels(left, palette);
            random_pixels += left;
            drain();
         end
         idle_on = ($urandom_range(0, 3) != 0);
         write_reg(REG_FRAME_WIDTH, pick_dim());
         write_reg(REG_FRAME_HEIGHT, pick_dim());
         write_reg(REG_ALPHA_Q8, pick_alpha());
         if ($urandom_range(0, 3) == 0) begin
            // Stop somewhere inside a frame, then narrow it and change the rest.
            left = $urandom_range(1, 2 * clamp_dim(width_reg) * clamp_dim(height_reg) - 1);
            queue_pixels(left, palette);
            random_pixels += left;
            drain();
            write_reg(REG_FRAME_WIDTH, $urandom_range(0, clamp_dim(width_reg)));
            write_reg(REG_FRAME_HEIGHT, pick_dim());
            write_reg(REG_ALPHA_Q8, pick_alpha());
         end else begin
            left = $urandom_range(1, 3) * frame_pixels_left();
            queue_pixels(left, palette);
            random_pixels += left;
            drain();
         end
      end

      if (mismatch_count == 0) begin
         $display("tb_dominant_channel_colorize_3x3_unit: done, clean");
      end else begin
         $display("tb_dominant_channel_colorize_3x3_unit: done, errors");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("tb_dominant_channel_colorize_3x3_unit: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
design/dcc_pkg.sv
design/dcc_stream_if.sv
design/dcc_ram.sv
design/dcc_window.sv
design/dcc_colorize.sv
design/dcc_out_fifo.sv
design/dominant_channel_colorize_3x3_unit.sv
sim/tb_dominant_channel_colorize_3x3_unit.sv
